>>> design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define HSVRGB_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsvrgb assertion failed: name");

// property checked at every edge, reset included
`define HSVRGB_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("hsvrgb assertion failed: name");

`endif

>>> design/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

    localparam int NUM_STAGES = 5;

    typedef logic [NUM_STAGES-1:0] t_stage_vec;
    typedef logic [2:0]            t_sector;
    typedef logic [7:0]            t_ftab [256];

    // hue sectors in the usual order
    localparam t_sector SEC_RED     = 3'd0;
    localparam t_sector SEC_YELLOW  = 3'd1;
    localparam t_sector SEC_GREEN   = 3'd2;
    localparam t_sector SEC_CYAN    = 3'd3;
    localparam t_sector SEC_BLUE    = 3'd4;
    localparam t_sector SEC_MAGENTA = 3'd5;

    localparam logic [7:0] START_YELLOW  = 8'd43;
    localparam logic [7:0] START_GREEN   = 8'd86;
    localparam logic [7:0] START_CYAN    = 8'd128;
    localparam logic [7:0] START_BLUE    = 8'd171;
    localparam logic [7:0] START_MAGENTA = 8'd214;

    localparam int SIZE_LONG  = 42;
    localparam int SIZE_SHORT = 41;

    function automatic t_sector sector_of(input logic [7:0] h);
        t_sector k;
        k = SEC_RED;
        if (h >= START_YELLOW)  k = SEC_YELLOW;
        if (h >= START_GREEN)   k = SEC_GREEN;
        if (h >= START_CYAN)    k = SEC_CYAN;
        if (h >= START_BLUE)    k = SEC_BLUE;
        if (h >= START_MAGENTA) k = SEC_MAGENTA;
        return k;
    endfunction

    function automatic logic [7:0] sector_start(input t_sector k);
        logic [7:0] s;
        unique case (k)
            SEC_YELLOW:  s = START_YELLOW;
            SEC_GREEN:   s = START_GREEN;
            SEC_CYAN:    s = START_CYAN;
            SEC_BLUE:    s = START_BLUE;
            SEC_MAGENTA: s = START_MAGENTA;
            default:     s = 8'd0;
        endcase
        return s;
    endfunction

    // fraction within the sector for every hue, built at elaboration
    function automatic t_ftab build_f_table();
        t_ftab   tab;
        t_sector k;
        int      d;
        for (int i = 0; i < 256; i++) begin
            k = sector_of(8'(i));
            d = i - int'(sector_start(k));
            if (k == SEC_GREEN || k == SEC_MAGENTA) begin
                tab[i] = 8'((d * 255) / SIZE_SHORT);
            end else begin
                tab[i] = 8'((d * 255) / SIZE_LONG);
            end
        end
        return tab;
    endfunction

    localparam t_ftab F_TABLE = build_f_table();

    // exact floor(x / 255) for any x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

>>> design/hsvrgb_if.sv
`default_nettype none

interface hsvrgb_hsv_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> design/hsv_to_rgb_8bit.sv
// an accepted request moves through the five-stage multiply pipeline to its result on o_rgb
// throughput: one request per cycle while the output is not stalled
// a stalled output fills empty stages first; input stalls only when all stages hold data
// reset (synchronous, active low) clears every stage valid bit; data registers are not reset
`default_nettype none

module hsv_to_rgb_8bit import hsvrgb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsvrgb_hsv_if.sink    i_hsv,
    hsvrgb_rgb_if.source  o_rgb
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    t_stage_vec            stage_en;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_rgb.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !r_vld[i] || stage_en[i+1];
        end
        n_vld[0] = stage_en[0] ? i_hsv.valid : r_vld[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            n_vld[i] = stage_en[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    hsvrgb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_en         (stage_en),
        .i_hue        (i_hsv.hue),
        .i_saturation (i_hsv.saturation),
        .i_brightness (i_hsv.brightness),
        .o_red        (o_rgb.red),
        .o_green      (o_rgb.green),
        .o_blue       (o_rgb.blue)
    );

    assign i_hsv.ready = stage_en[0];
    assign o_rgb.valid = r_vld[NUM_STAGES-1];

endmodule

`default_nettype wire

>>> design/hsvrgb_datapath.sv
`default_nettype none

module hsvrgb_datapath import hsvrgb_pkg::*; (
    input  logic       i_clk,
    input  t_stage_vec i_en,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_brightness,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    // stage 1: sector and fraction
    t_sector     r1_k;
    logic [7:0]  r1_f;
    logic [7:0]  r1_s;
    logic [7:0]  r1_v;
    // stage 2: first products
    t_sector     r2_k;
    logic [7:0]  r2_v;
    logic [15:0] r2_sf;
    logic [15:0] r2_snf;
    logic [15:0] r2_pm;
    // stage 3: scaled amounts and p
    t_sector     r3_k;
    logic [7:0]  r3_v;
    logic [7:0]  r3_a_q;
    logic [7:0]  r3_a_t;
    logic [7:0]  r3_p;
    // stage 4: second products
    t_sector     r4_k;
    logic [7:0]  r4_v;
    logic [7:0]  r4_p;
    logic [15:0] r4_qm;
    logic [15:0] r4_tm;
    // stage 5: routed channels
    logic [7:0]  r5_red;
    logic [7:0]  r5_green;
    logic [7:0]  r5_blue;

    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic [7:0]  q;
    logic [7:0]  t;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_k <= sector_of(i_hue);
            r1_f <= F_TABLE[i_hue];
            r1_s <= i_saturation;
            r1_v <= i_brightness;
        end
        if (i_en[1]) begin
            r2_k   <= r1_k;
            r2_v   <= r1_v;
            r2_sf  <= 16'(r1_s) * 16'(r1_f);
            r2_snf <= 16'(r1_s) * 16'(8'd255 - r1_f);
            r2_pm  <= 16'(r1_v) * 16'(8'd255 - r1_s);
        end
        if (i_en[2]) begin
            r3_k   <= r2_k;
            r3_v   <= r2_v;
            r3_a_q <= div255(r2_sf);
            r3_a_t <= div255(r2_snf);
            r3_p   <= div255(r2_pm);
        end
        if (i_en[3]) begin
            r4_k  <= r3_k;
            r4_v  <= r3_v;
            r4_p  <= r3_p;
            r4_qm <= 16'(r3_v) * 16'(8'd255 - r3_a_q);
            r4_tm <= 16'(r3_v) * 16'(8'd255 - r3_a_t);
        end
        if (i_en[4]) begin
            r5_red   <= n_red;
            r5_green <= n_green;
            r5_blue  <= n_blue;
        end
    end

    always_comb begin
        q = div255(r4_qm);
        t = div255(r4_tm);
        unique case (r4_k)
            SEC_RED: begin
                n_red = r4_v; n_green = t;    n_blue = r4_p;
            end
            SEC_YELLOW: begin
                n_red = q;    n_green = r4_v; n_blue = r4_p;
            end
            SEC_GREEN: begin
                n_red = r4_p; n_green = r4_v; n_blue = t;
            end
            SEC_CYAN: begin
                n_red = r4_p; n_green = q;    n_blue = r4_v;
            end
            SEC_BLUE: begin
                n_red = t;    n_green = r4_p; n_blue = r4_v;
            end
            default: begin
                n_red = r4_v; n_green = r4_p; n_blue = q;
            end
        endcase
    end

    assign o_red   = r5_red;
    assign o_green = r5_green;
    assign o_blue  = r5_blue;

endmodule

`default_nettype wire

>>> design/hsvrgb_checker.sv
`default_nettype none
`include "assert_macros.svh"

module hsvrgb_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire [7:0] i_saturation,
    input wire [7:0] i_brightness,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_red,
    input wire [7:0] i_green,
    input wire [7:0] i_blue
);

    wire in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // pipeline comes out of reset empty
    `HSVRGB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

    // with the output taken while it travels, an accepted request reaches the output
    `HSVRGB_ASSERT(a_latency, i_clk, i_rst_n, in_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)

    // gray request gives brightness on all three channels
    `HSVRGB_ASSERT(a_gray, i_clk, i_rst_n, in_acc && i_saturation == 8'd0 ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_red == $past(i_brightness, 5) && i_green == i_red && i_blue == i_red)

    // stalled result holds
    `HSVRGB_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue))

endmodule

bind hsv_to_rgb_8bit hsvrgb_checker u_hsvrgb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_hsv.valid),
    .i_in_ready   (i_hsv.ready),
    .i_saturation (i_hsv.saturation),
    .i_brightness (i_hsv.brightness),
    .i_out_valid  (o_rgb.valid),
    .i_out_ready  (o_rgb.ready),
    .i_red        (o_rgb.red),
    .i_green      (o_rgb.green),
    .i_blue       (o_rgb.blue)
);

`default_nettype wire
